@@ design/bdasc_pkg.sv @@
// Package: widths, constants and controller/datapath command types for the decimal converter.
package bdasc_pkg;

	// Width of the input field and of the part of it that is converted
	localparam int VALUE_FIELD_W = 32;
	localparam int VALUE_WIDTH   = 32;
	localparam int CONV_WIDTH    = (VALUE_WIDTH < VALUE_FIELD_W) ? VALUE_WIDTH : VALUE_FIELD_W;

	// Decimal digits needed for 2**CONV_WIDTH - 1 (1233/4096 approximates log10(2))
	localparam int NUM_DIGITS = ((CONV_WIDTH * 1233) >> 12) + 1;
	localparam int BCD_W      = NUM_DIGITS * 4;

	// Counter widths
	localparam int STEP_W = $clog2(CONV_WIDTH);
	localparam int DIG_W  = $clog2(NUM_DIGITS + 1);

	// Output character field
	localparam int CHAR_W = 6;
	localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

	// Commands from controller to datapath
	typedef struct packed {
		logic load;   // capture a new value, clear digits
		logic shift;  // one double dabble step
		logic drop;   // shift the top digit out
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic shift_done;  // this is the final shift step
		logic top_zero;    // leading digit is zero
		logic last_digit;  // one digit remains
	} dp_status_t;

endpackage

@@ design/bdasc_value_if.sv @@
// Interface: input channel carrying one binary value per beat.
interface bdasc_value_if import bdasc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [VALUE_FIELD_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

@@ design/bdasc_digit_if.sv @@
// Interface: output channel carrying one ASCII digit per beat.
interface bdasc_digit_if import bdasc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] digit_char;
	logic              last;

	modport source (output valid, output digit_char, output last, input ready);
	modport sink (input valid, input digit_char, input last, output ready);
endinterface

@@ design/binary_to_decimal_ascii.sv @@
// Sequence: a load, one double dabble shift per converted bit (CONV_WIDTH = 32), a skip step per
// leading zero dropped (up to 9) and a final check step, then one beat per digit while digit_ch is ready.
// Throughput: one value at a time; a new value is taken only after the last digit has gone,
// set by the bit-serial double dabble shift loop and the one-digit-per-cycle output when not stalled.
// Reset: arst_n asynchronously returns the controller to idle; no state spans values.
module binary_to_decimal_ascii import bdasc_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	bdasc_value_if.sink    value_ch,
	bdasc_digit_if.source  digit_ch
);

	dp_cmd_t    cmd;
	dp_status_t status;

	bdasc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (value_ch.valid),
		.in_ready  (value_ch.ready),
		.out_valid (digit_ch.valid),
		.out_ready (digit_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	bdasc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.value      (value_ch.value),
		.status     (status),
		.digit_char (digit_ch.digit_char),
		.last       (digit_ch.last)
	);

endmodule

@@ design/bdasc_dp.sv @@
// Datapath: binary shift register, BCD digit register and the step and digit counters.
module bdasc_dp import bdasc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  cmd,
	input  logic [VALUE_FIELD_W-1:0] value,
	output dp_status_t               status,
	output logic [CHAR_W-1:0]        digit_char,
	output logic                     last
);

	logic [CONV_WIDTH-1:0] bin_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      bcd_adj;
	logic [STEP_W-1:0]     step_q;
	logic [DIG_W-1:0]      dig_q;
	logic [3:0]            top_digit;

	// Add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	// Shift registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= value[CONV_WIDTH-1:0];
			bcd_q <= '0;
		end else if (cmd.shift) begin
			bin_q <= bin_q << 1;
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[CONV_WIDTH-1]};
		end else if (cmd.drop) begin
			bcd_q <= bcd_q << 4;
		end
	end

	// Step and remaining-digit counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			dig_q  <= '0;
		end else if (cmd.load) begin
			step_q <= '0;
			dig_q  <= DIG_W'(NUM_DIGITS);
		end else if (cmd.shift) begin
			step_q <= step_q + STEP_W'(1);
		end else if (cmd.drop) begin
			dig_q <= dig_q - DIG_W'(1);
		end
	end

	// Status and output digit
	assign top_digit         = bcd_q[BCD_W-1 -: 4];
	assign status.shift_done = (step_q == STEP_W'(CONV_WIDTH - 1));
	assign status.top_zero   = (top_digit == 4'd0);
	assign status.last_digit = (dig_q == DIG_W'(1));
	assign digit_char        = ASCII_ZERO + {{(CHAR_W-4){1'b0}}, top_digit};
	assign last              = status.last_digit;

endmodule

@@ design/bdasc_ctrl.sv @@
// Controller: sequences load, double dabble shifts, leading zero skip and digit beats.
module bdasc_ctrl import bdasc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_SKIP,
		ST_EMIT
	} state_t;

	state_t state_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					if (status.shift_done) state_q <= ST_SKIP;
				end
				ST_SKIP: begin
					if (!(status.top_zero && !status.last_digit)) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_ready && status.last_digit) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Handshake and datapath commands
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		out_valid = (state_q == ST_EMIT);
		cmd.load  = in_ready && in_valid;
		cmd.shift = (state_q == ST_SHIFT);
		cmd.drop  = ((state_q == ST_SKIP) && status.top_zero && !status.last_digit)
			|| (out_valid && out_ready);
	end

endmodule
